// ----- rtl/stp_pkg.sv -----
// ----------------------------------------------------------------------------
// stp_pkg
// shared widths, codes and reset values of the stepper ramp step generator
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int SPD_W  = 10;
    localparam int NUM_W  = 20;
    localparam int HP_W   = 16;
    localparam int TIME_W = 32;
    localparam int IVL_W  = 16;
    localparam int MASK_W = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    typedef logic [1:0]          op_t;
    typedef logic [SPD_W-1:0]    speed_t;
    typedef logic [HP_W-1:0]     half_period_t;
    typedef logic [TIME_W-1:0]   time_t;

    localparam op_t OP_SET_TARGET = 2'd0;
    localparam op_t OP_ESTOP      = 2'd1;
    localparam op_t OP_RAMP_TICK  = 2'd2;
    localparam op_t OP_STEP_TICK  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_IVL   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_INVERT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HP_NUMER   = 3'd4;

    localparam speed_t              MAX_SPEED_RST  = 10'd800;
    localparam speed_t              ACCEL_STEP_RST = 10'd50;
    localparam logic [IVL_W-1:0]    RAMP_IVL_RST   = 16'd50;
    localparam logic [MASK_W-1:0]   DIR_INVERT_RST = 4'd10;
    localparam logic [NUM_W-1:0]    HP_NUMER_RST   = 20'd500000;
    localparam half_period_t        HALF_PERIOD_RST = 16'd1000;

endpackage

// ----- rtl/stp_div.sv -----
// ----------------------------------------------------------------------------
// stp_div
// restoring divider, one quotient bit per cycle, numerator over speed
// ----------------------------------------------------------------------------
module stp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [stp_pkg::NUM_W-1:0]   numer,
    input  logic [stp_pkg::SPD_W-1:0]   denom,
    output logic                        done,
    output logic [stp_pkg::NUM_W-1:0]   quot
);
    import stp_pkg::*;

    localparam logic [4:0] CNT_LAST = 5'(NUM_W - 1);

    logic             busy_reg;
    logic             done_reg;
    logic [4:0]       cnt_reg;
    logic [SPD_W-1:0] rem_reg;
    logic [SPD_W-1:0] den_reg;
    logic [NUM_W-1:0] quo_reg;

    logic [SPD_W:0]   shifted;
    logic [SPD_W:0]   diff;
    logic             ge;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= numer;
            rem_reg <= '0;
            den_reg <= denom;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SPD_W-1:0] : shifted[SPD_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ----- rtl/stepper_ramp_step_generator.sv -----
// ----------------------------------------------------------------------------
// stepper_ramp_step_generator
// stepper channels with linear speed ramps, step toggling and status beats
// ----------------------------------------------------------------------------
// sequence: set target / stop pass S_CMD and S_OUT, step tick visits each motor in S_STEP,
//   ramp tick runs S_RAMP_CHK and S_RAMP_UPD per motor, with a divider wait per due motor
// throughput: one beat at a time; the motor loop and the shared divider set it
// a finished beat waits in the output register while the next one is taken
// reset: asynchronous; motor state, config, sequencer and output valid back to power-up values
// ----------------------------------------------------------------------------
module stepper_ramp_step_generator
#(
    parameter int NUM_MOTORS = 4
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [stp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [stp_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input beats
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // motor[1:0], target_speed[11:2], reverse[12], time_now[44:13], zero pad
    input  logic [47:0]                       s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                        s_axis_tuser,
    // result beats
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // step_lines[3:0], dir_lines[7:4], running_lines[11:8], motor_speed[21:12],
    // motor_steps[53:22], motor_half_period[69:54], zero pad
    output logic [71:0]                       m_axis_tdata
);
    import stp_pkg::*;

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_MOTORS - 1);
    localparam logic [4:0]       NUM_M5   = 5'(NUM_MOTORS);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CMD      = 3'd1;
    localparam logic [2:0] S_RAMP_CHK = 3'd2;
    localparam logic [2:0] S_RAMP_UPD = 3'd3;
    localparam logic [2:0] S_DIV      = 3'd4;
    localparam logic [2:0] S_STEP     = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    // config registers
    speed_t             max_speed_reg;
    speed_t             accel_step_reg;
    logic [IVL_W-1:0]   ramp_ivl_reg;
    logic [MASK_W-1:0]  dir_invert_reg;
    logic [NUM_W-1:0]   hp_numer_reg;

    // motor state
    speed_t             target_spd_reg  [NUM_MOTORS];
    speed_t             current_spd_reg [NUM_MOTORS];
    half_period_t       half_period_reg [NUM_MOTORS];
    time_t              last_step_reg   [NUM_MOTORS];
    time_t              last_ramp_reg   [NUM_MOTORS];
    logic [31:0]        step_count_reg  [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] step_level_reg;
    logic [NUM_MOTORS-1:0] dir_level_reg;
    logic [NUM_MOTORS-1:0] running_reg;

    // sequencer
    logic [2:0]         state_reg, state_next;
    logic [IDX_W-1:0]   idx_reg;
    logic               due_reg;
    op_t                op_reg;
    logic [1:0]         motor_reg;
    speed_t             tspd_reg;
    logic               rev_reg;
    time_t              now_reg;

    // output register
    logic               out_valid_reg;
    logic [71:0]        out_data_reg;

    // per-motor selection
    logic [IDX_W-1:0]   sel_idx;
    logic [4:0]         mot_ext;
    logic [IDX_W-1:0]   mot_idx;
    logic               mot_valid;
    logic [4:0]         idx_ext;
    logic               inv_bit;
    speed_t             cur_sel;
    speed_t             tgt_sel;
    half_period_t       hp_sel;
    time_t              ramp_elapsed;
    time_t              step_elapsed;
    logic [SPD_W:0]     spd_up;
    speed_t             spd_gap;
    speed_t             spd_new;
    logic               step_due;
    logic               last_motor;
    logic [3:0]         step_lines;
    logic [3:0]         dir_lines;
    logic [3:0]         run_lines;

    // divider
    logic               div_start;
    logic               div_done;
    logic [NUM_W-1:0]   div_quot;
    half_period_t       hp_sat;

    assign mot_ext   = {3'b000, motor_reg};
    assign mot_idx   = mot_ext[IDX_W-1:0];
    assign mot_valid = mot_ext < NUM_M5;
    assign sel_idx   = (state_reg == S_OUT) ? mot_idx : idx_reg;
    assign idx_ext   = 5'(idx_reg);
    assign inv_bit   = (idx_ext < 5'd4) ? dir_invert_reg[idx_ext[1:0]] : 1'b0;
    assign last_motor = idx_reg == IDX_LAST;

    assign cur_sel = current_spd_reg[sel_idx];
    assign tgt_sel = target_spd_reg[sel_idx];
    assign hp_sel  = half_period_reg[sel_idx];

    assign ramp_elapsed = now_reg - last_ramp_reg[idx_reg];
    assign step_elapsed = now_reg - last_step_reg[idx_reg];
    assign step_due = running_reg[idx_reg] && (hp_sel != '0)
                      && (step_elapsed >= TIME_W'(hp_sel));

    assign spd_up  = {1'b0, cur_sel} + {1'b0, accel_step_reg};
    assign spd_gap = cur_sel - tgt_sel;

    always_comb
    begin
        if (cur_sel < tgt_sel)
            spd_new = (spd_up > {1'b0, tgt_sel}) ? tgt_sel : spd_up[SPD_W-1:0];
        else if (cur_sel > tgt_sel)
            spd_new = (spd_gap > accel_step_reg) ? (cur_sel - accel_step_reg) : tgt_sel;
        else
            spd_new = cur_sel;
    end

    assign div_start = (state_reg == S_RAMP_UPD) && due_reg && (spd_new != '0);
    assign hp_sat = (|div_quot[NUM_W-1:HP_W]) ? {HP_W{1'b1}} : div_quot[HP_W-1:0];

    stp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (hp_numer_reg),
        .denom (spd_new),
        .done  (div_done),
        .quot  (div_quot)
    );

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lines
            if (g < NUM_MOTORS)
            begin : g_on
                assign step_lines[g] = step_level_reg[g];
                assign dir_lines[g]  = dir_level_reg[g];
                assign run_lines[g]  = running_reg[g];
            end
            else
            begin : g_off
                assign step_lines[g] = 1'b0;
                assign dir_lines[g]  = 1'b0;
                assign run_lines[g]  = 1'b0;
            end
        end
    endgenerate

    assign s_axis_tready = state_reg == S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (s_axis_tuser)
                        OP_RAMP_TICK: state_next = S_RAMP_CHK;
                        OP_STEP_TICK: state_next = S_STEP;
                        default:      state_next = S_CMD;
                    endcase
                end
            end
            S_CMD:      state_next = S_OUT;
            S_RAMP_CHK: state_next = S_RAMP_UPD;
            S_RAMP_UPD:
            begin
                if (div_start)
                    state_next = S_DIV;
                else
                    state_next = last_motor ? S_OUT : S_RAMP_CHK;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = last_motor ? S_OUT : S_RAMP_CHK;
            end
            S_STEP:
            begin
                if (last_motor)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg  <= MAX_SPEED_RST;
            accel_step_reg <= ACCEL_STEP_RST;
            ramp_ivl_reg   <= RAMP_IVL_RST;
            dir_invert_reg <= DIR_INVERT_RST;
            hp_numer_reg   <= HP_NUMER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_SPEED:  max_speed_reg  <= cfg_data[SPD_W-1:0];
                CFG_ACCEL_STEP: accel_step_reg <= cfg_data[SPD_W-1:0];
                CFG_RAMP_IVL:   ramp_ivl_reg   <= cfg_data[IVL_W-1:0];
                CFG_DIR_INVERT: dir_invert_reg <= cfg_data[MASK_W-1:0];
                CFG_HP_NUMER:   hp_numer_reg   <= cfg_data[NUM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and motor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            due_reg        <= 1'b0;
            step_level_reg <= '0;
            dir_level_reg  <= '0;
            running_reg    <= '0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                target_spd_reg[i]  <= '0;
                current_spd_reg[i] <= '0;
                half_period_reg[i] <= HALF_PERIOD_RST;
                last_step_reg[i]   <= '0;
                last_ramp_reg[i]   <= '0;
                step_count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                end
                S_CMD:
                begin
                    if (mot_valid)
                    begin
                        if (op_reg == OP_SET_TARGET)
                        begin
                            target_spd_reg[mot_idx] <=
                                (tspd_reg > max_speed_reg) ? max_speed_reg : tspd_reg;
                        end
                        else
                        begin
                            target_spd_reg[mot_idx]  <= '0;
                            current_spd_reg[mot_idx] <= '0;
                            running_reg[mot_idx]     <= 1'b0;
                            step_level_reg[mot_idx]  <= 1'b0;
                        end
                    end
                end
                S_RAMP_CHK:
                begin
                    due_reg <= ramp_elapsed >= TIME_W'(ramp_ivl_reg);
                end
                S_RAMP_UPD:
                begin
                    if (due_reg)
                    begin
                        last_ramp_reg[idx_reg]   <= now_reg;
                        current_spd_reg[idx_reg] <= spd_new;
                        if (spd_new == '0)
                        begin
                            running_reg[idx_reg]    <= 1'b0;
                            step_level_reg[idx_reg] <= 1'b0;
                        end
                        else
                        begin
                            dir_level_reg[idx_reg] <= rev_reg ^ inv_bit;
                        end
                    end
                    if (!div_start && !last_motor)
                        idx_reg <= idx_reg + 1'b1;
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        half_period_reg[idx_reg] <= hp_sat;
                        running_reg[idx_reg]     <= 1'b1;
                        if (!last_motor)
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_STEP:
                begin
                    if (step_due)
                    begin
                        last_step_reg[idx_reg]  <= now_reg;
                        step_level_reg[idx_reg] <= ~step_level_reg[idx_reg];
                        if (!step_level_reg[idx_reg])
                            step_count_reg[idx_reg] <= step_count_reg[idx_reg] + 32'd1;
                    end
                    if (!last_motor)
                        idx_reg <= idx_reg + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // captured input beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg    <= s_axis_tuser;
            motor_reg <= s_axis_tdata[1:0];
            tspd_reg  <= s_axis_tdata[11:2];
            rev_reg   <= s_axis_tdata[12];
            now_reg   <= s_axis_tdata[44:13];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || m_axis_tready))
        begin
            out_data_reg <= {2'b00,
                             mot_valid ? hp_sel : '0,
                             mot_valid ? step_count_reg[mot_idx] : 32'd0,
                             mot_valid ? cur_sel : '0,
                             run_lines, dir_lines, step_lines};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
